[hdl/assert_macros.svh]
// assertion macros used by the classifier top level
// no dependencies; the user must provide aclk and aresetn in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every rising edge outside reset
`define GNB_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// condition that must never be seen outside reset
`define GNB_NEVER(label, cond, msg) \
    `GNB_ASSERT(label, !(cond), msg)

`endif

[hdl/gnb_pkg.sv]
// shared types and constants of the gaussian naive bayes classifier
// no dependencies
package gnb_pkg;

    // action codes carried in s_tuser
    localparam logic [1:0] ACT_CLEAR   = 2'd0;
    localparam logic [1:0] ACT_TRAIN   = 2'd1;
    localparam logic [1:0] ACT_PREDICT = 2'd2;

    // label code that is never a class
    localparam logic [1:0] LABEL_UNKNOWN = 2'd3;

    // 1 / (2 ln 2) in q16
    localparam logic [15:0] INV_2LN2 = 16'd47274;

    localparam int LOG_FRAC  = 16;
    localparam int LOG_ITERS = 16;
    localparam int MANT_W    = 31;   // q1.30 mantissa
    localparam int FEAT_IN   = 4;
    localparam int X_W       = 16;
    localparam int SCORE_W   = 64;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_TRAIN_CHK,
        ST_TRAIN_MUL,
        ST_TRAIN_ACC,
        ST_CLASS,
        ST_LOG_NORM,
        ST_LOG_MUL,
        ST_LOG_SQ,
        ST_LOG_END,
        ST_MEAN_DIV,
        ST_MEAN_WAIT,
        ST_MSQ_DIV,
        ST_MSQ_WAIT,
        ST_M2_MUL,
        ST_M2_END,
        ST_DD_MUL,
        ST_DQ_MUL,
        ST_DQ_END,
        ST_Q_WAIT,
        ST_CLASS_END,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic clear;
        logic inc;
        logic acc;
    } stats_cmd_t;

endpackage

[hdl/gaussian_naive_bayes_classifier.sv]
// top level of the gaussian naive bayes classifier: sequencer and io
// depends on gnb_pkg, gnb_stats, gnb_div, gnb_mul, assert_macros.svh
//
// usage
//  - s_ channel takes one item per handshake: s_tuser holds the action
//    (clear, train, predict), s_tdata the label and four q8.8 features
//  - clear zeroes the statistics, train adds the sample to its class;
//    neither gives a result
//  - predict gives one result item on the m_ channel: class in m_tdata,
//    m_tuser set when no class has training data
//  - cfg_ channel writes min_variance (always ready, write only while idle)
//  - train checks the class count, then squares and adds each feature in
//    turn; predict walks every class and feature through one shared
//    divider (three divisions per feature) and one shared multiplier
//  - the divider loop sets the predict time; the block takes one item at
//    a time and s_tready is low until the item is done
//  - a finished result sits in the output register; if m_tready is low
//    the next item may still be accepted and runs until its own result
//    is due, then waits for the register to drain
//  - synchronous active-low reset clears statistics, sets min_variance
//    to 1 and drops m_tvalid
`include "assert_macros.svh"

module gaussian_naive_bayes_classifier #(
    parameter int NUM_CLASSES  = 3,
    parameter int NUM_FEATURES = 4,
    parameter int COUNT_WIDTH  = 16,
    parameter int FRAC_BITS    = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input items
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // class_label[1:0], pos_s, pos_d, rate_s, rate_d, zero pad
    input  logic [1:0]  s_tuser,   // action[1:0]
    // result items
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // predicted_class[1:0], zero pad
    output logic        m_tuser,   // status
    // configuration
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data   // min_variance
);

    localparam int CLS_W  = $clog2(NUM_CLASSES);
    localparam int FEAT_W = (NUM_FEATURES > 1) ? $clog2(NUM_FEATURES) : 1;
    localparam int SUM_W  = 16 + COUNT_WIDTH;
    localparam int SQ_W   = 32 + COUNT_WIDTH;
    localparam int DW     = (SQ_W > 48) ? SQ_W : 48;
    localparam int MW     = gnb_pkg::MANT_W;
    localparam int SW     = gnb_pkg::SCORE_W;

    gnb_pkg::state_t state_reg, state_next;

    logic [15:0]              min_var_reg;
    logic signed [15:0]       x_reg [gnb_pkg::FEAT_IN];
    logic [CLS_W-1:0]         cls_reg, cls_next;
    logic [FEAT_W-1:0]        feat_reg, feat_next;
    logic [CLS_W-1:0]         best_reg, best_next;
    logic                     found_reg, found_next;
    logic signed [SW-1:0]     score_reg, score_next;
    logic signed [SW-1:0]     best_score_reg, best_score_next;
    logic signed [17:0]       m_reg, m_next;
    logic [30:0]              msq_reg, msq_next;
    logic [30:0]              var_reg, var_next;
    logic [MW-1:0]            log_y_reg, log_y_next;
    logic [4:0]               log_e_reg, log_e_next;
    logic [15:0]              log_frac_reg, log_frac_next;
    logic [3:0]               log_iter_reg, log_iter_next;
    logic                     log_kind_reg, log_kind_next;   // 0 count, 1 variance
    logic                     out_valid_reg, out_valid_next;
    logic [1:0]               out_cls_reg, out_cls_next;
    logic                     out_status_reg, out_status_next;

    logic                     in_fire;
    logic                     latch_x;
    gnb_pkg::stats_cmd_t      cmd;
    logic [COUNT_WIDTH-1:0]   rd_count;
    logic signed [SUM_W-1:0]  rd_sum;
    logic [SQ_W-1:0]          rd_sq;
    logic [SUM_W-1:0]         sum_mag;

    logic [31:0]              mul_a, mul_b;
    logic [63:0]              mul_p;

    logic                     div_start;
    logic [DW-1:0]            div_dividend, div_divisor;
    logic                     div_busy, div_done, div_rem_nz;
    logic [DW-1:0]            div_q;

    logic [FEAT_W+1:0]        fidx;
    logic signed [15:0]       x_cur;
    logic [17:0]              mmag;
    logic signed [17:0]       d_val;
    logic [17:0]              dmag;
    logic [31:0]              v2;
    logic [31:0]              vsh;
    logic [15:0]              floor_v;
    logic [32:0]              sq_top;
    logic [SW-1:0]            log_val;
    logic                     cls_last, feat_last;
    logic [CLS_W+1:0]         label_ext;
    logic [17:0]              q_mean;

    // ------------------------------------------------------------------
    // shared units
    // ------------------------------------------------------------------
    gnb_stats #(
        .NUM_CLASSES (NUM_CLASSES),
        .NUM_FEATURES(NUM_FEATURES),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_stats (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .cls     (cls_reg),
        .feat    (feat_reg),
        .add_x   (x_cur),
        .add_sq  (mul_p[31:0]),
        .rd_count(rd_count),
        .rd_sum  (rd_sum),
        .rd_sq   (rd_sq)
    );

    gnb_mul u_mul (
        .aclk(aclk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (mul_p)
    );

    gnb_div #(.DW(DW)) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .dividend(div_dividend),
        .divisor (div_divisor),
        .busy    (div_busy),
        .done    (div_done),
        .quotient(div_q),
        .rem_nz  (div_rem_nz)
    );

    // ------------------------------------------------------------------
    // datapath helpers
    // ------------------------------------------------------------------
    assign in_fire   = s_tvalid && s_tready;
    assign s_tready  = (state_reg == gnb_pkg::ST_IDLE);
    assign cfg_ready = 1'b1;

    // features past the four input fields read as zero
    assign fidx  = (FEAT_W + 2)'(feat_reg);
    assign x_cur = (fidx < (FEAT_W + 2)'(gnb_pkg::FEAT_IN)) ? x_reg[fidx[1:0]] : 16'sd0;

    assign sum_mag = rd_sum[SUM_W-1] ? SUM_W'(-rd_sum) : SUM_W'(rd_sum);
    assign mmag    = m_reg[17] ? 18'(-m_reg) : 18'(m_reg);
    assign d_val   = 18'(x_cur) - m_reg;
    assign dmag    = d_val[17] ? 18'(-d_val) : 18'(d_val);
    assign floor_v = (min_var_reg == 16'd0) ? 16'd1 : min_var_reg;
    assign v2      = ({1'b0, msq_reg} > mul_p[31:0]) ? ({1'b0, msq_reg} - mul_p[31:0]) : 32'd0;
    assign vsh     = v2 >> FRAC_BITS;
    assign sq_top  = mul_p[62:30];
    assign log_val = SW'({log_e_reg, log_frac_reg});
    assign q_mean  = div_q[17:0] + 18'(div_rem_nz);

    assign cls_last  = (cls_reg == CLS_W'(NUM_CLASSES - 1));
    assign feat_last = (feat_reg == FEAT_W'(NUM_FEATURES - 1));
    assign label_ext = (CLS_W + 2)'(s_tdata[1:0]);

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    always_comb begin
        state_next      = state_reg;
        cls_next        = cls_reg;
        feat_next       = feat_reg;
        best_next       = best_reg;
        found_next      = found_reg;
        score_next      = score_reg;
        best_score_next = best_score_reg;
        m_next          = m_reg;
        msq_next        = msq_reg;
        var_next        = var_reg;
        log_y_next      = log_y_reg;
        log_e_next      = log_e_reg;
        log_frac_next   = log_frac_reg;
        log_iter_next   = log_iter_reg;
        log_kind_next   = log_kind_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_cls_next    = out_cls_reg;
        out_status_next = out_status_reg;
        latch_x         = 1'b0;
        cmd             = '0;
        mul_a           = '0;
        mul_b           = '0;
        div_start       = 1'b0;
        div_dividend    = '0;
        div_divisor     = '0;

        case (state_reg)
            gnb_pkg::ST_IDLE: begin
                if (in_fire) begin
                    latch_x = 1'b1;
                    case (s_tuser)
                        gnb_pkg::ACT_CLEAR: begin
                            cmd.clear = 1'b1;
                        end
                        gnb_pkg::ACT_TRAIN: begin
                            if (s_tdata[1:0] != gnb_pkg::LABEL_UNKNOWN &&
                                label_ext < (CLS_W + 2)'(NUM_CLASSES)) begin
                                cls_next   = label_ext[CLS_W-1:0];
                                state_next = gnb_pkg::ST_TRAIN_CHK;
                            end
                        end
                        gnb_pkg::ACT_PREDICT: begin
                            cls_next   = '0;
                            found_next = 1'b0;
                            best_next  = '0;
                            state_next = gnb_pkg::ST_CLASS;
                        end
                        default: begin
                        end
                    endcase
                end
            end

            gnb_pkg::ST_TRAIN_CHK: begin
                feat_next = '0;
                // a saturated class ignores the sample
                if (rd_count == {COUNT_WIDTH{1'b1}}) begin
                    state_next = gnb_pkg::ST_IDLE;
                end else begin
                    cmd.inc    = 1'b1;
                    state_next = gnb_pkg::ST_TRAIN_MUL;
                end
            end

            gnb_pkg::ST_TRAIN_MUL: begin
                mul_a      = 32'(x_cur[15] ? 17'(-17'(x_cur)) : 17'(x_cur));
                mul_b      = mul_a;
                state_next = gnb_pkg::ST_TRAIN_ACC;
            end

            gnb_pkg::ST_TRAIN_ACC: begin
                cmd.acc = 1'b1;
                if (feat_last) begin
                    state_next = gnb_pkg::ST_IDLE;
                end else begin
                    feat_next  = feat_reg + 1'b1;
                    state_next = gnb_pkg::ST_TRAIN_MUL;
                end
            end

            gnb_pkg::ST_CLASS: begin
                feat_next = '0;
                if (rd_count == '0) begin
                    // empty class is skipped
                    if (cls_last) begin
                        state_next = gnb_pkg::ST_DONE;
                    end else begin
                        cls_next = cls_reg + 1'b1;
                    end
                end else begin
                    score_next    = '0;
                    log_y_next    = MW'(rd_count);
                    log_e_next    = 5'(MW - 1);
                    log_kind_next = 1'b0;
                    state_next    = gnb_pkg::ST_LOG_NORM;
                end
            end

            // log2 in q16: msb search one bit a cycle, then squaring rounds
            gnb_pkg::ST_LOG_NORM: begin
                log_frac_next = '0;
                log_iter_next = '0;
                if (log_y_reg[MW-1]) begin
                    state_next = gnb_pkg::ST_LOG_MUL;
                end else begin
                    log_y_next = {log_y_reg[MW-2:0], 1'b0};
                    log_e_next = log_e_reg - 1'b1;
                end
            end

            gnb_pkg::ST_LOG_MUL: begin
                mul_a      = 32'(log_y_reg);
                mul_b      = 32'(log_y_reg);
                state_next = gnb_pkg::ST_LOG_SQ;
            end

            gnb_pkg::ST_LOG_SQ: begin
                if (sq_top[31]) begin
                    log_y_next    = sq_top[31:1];
                    log_frac_next = {log_frac_reg[14:0], 1'b1};
                end else begin
                    log_y_next    = sq_top[30:0];
                    log_frac_next = {log_frac_reg[14:0], 1'b0};
                end
                log_iter_next = log_iter_reg + 1'b1;
                if (log_iter_reg == 4'(gnb_pkg::LOG_ITERS - 1)) begin
                    state_next = gnb_pkg::ST_LOG_END;
                end else begin
                    state_next = gnb_pkg::ST_LOG_MUL;
                end
            end

            gnb_pkg::ST_LOG_END: begin
                if (!log_kind_reg) begin
                    score_next = score_reg + (log_val <<< 1);
                    state_next = gnb_pkg::ST_MEAN_DIV;
                end else begin
                    score_next = score_reg - log_val;
                    if (feat_last) begin
                        state_next = gnb_pkg::ST_CLASS_END;
                    end else begin
                        feat_next  = feat_reg + 1'b1;
                        state_next = gnb_pkg::ST_MEAN_DIV;
                    end
                end
            end

            gnb_pkg::ST_MEAN_DIV: begin
                div_start    = 1'b1;
                div_dividend = DW'(sum_mag);
                div_divisor  = DW'(rd_count);
                state_next   = gnb_pkg::ST_MEAN_WAIT;
            end

            gnb_pkg::ST_MEAN_WAIT: begin
                if (div_done) begin
                    // floor division: negative sums round away from zero
                    m_next     = rd_sum[SUM_W-1] ? -$signed(q_mean) : $signed(div_q[17:0]);
                    state_next = gnb_pkg::ST_MSQ_DIV;
                end
            end

            gnb_pkg::ST_MSQ_DIV: begin
                div_start    = 1'b1;
                div_dividend = DW'(rd_sq);
                div_divisor  = DW'(rd_count);
                state_next   = gnb_pkg::ST_MSQ_WAIT;
            end

            gnb_pkg::ST_MSQ_WAIT: begin
                if (div_done) begin
                    msq_next   = div_q[30:0];
                    state_next = gnb_pkg::ST_M2_MUL;
                end
            end

            gnb_pkg::ST_M2_MUL: begin
                mul_a      = 32'(mmag);
                mul_b      = 32'(mmag);
                state_next = gnb_pkg::ST_M2_END;
            end

            gnb_pkg::ST_M2_END: begin
                // variance floored at min_variance
                var_next   = (vsh < 32'(floor_v)) ? 31'(floor_v) : vsh[30:0];
                state_next = gnb_pkg::ST_DD_MUL;
            end

            gnb_pkg::ST_DD_MUL: begin
                mul_a      = 32'(dmag);
                mul_b      = 32'(dmag);
                state_next = gnb_pkg::ST_DQ_MUL;
            end

            gnb_pkg::ST_DQ_MUL: begin
                mul_a      = mul_p[31:0];
                mul_b      = 32'(gnb_pkg::INV_2LN2);
                state_next = gnb_pkg::ST_DQ_END;
            end

            gnb_pkg::ST_DQ_END: begin
                div_start    = 1'b1;
                div_dividend = DW'(mul_p[47:0]);
                div_divisor  = DW'(var_reg) << FRAC_BITS;
                state_next   = gnb_pkg::ST_Q_WAIT;
            end

            gnb_pkg::ST_Q_WAIT: begin
                if (div_done) begin
                    score_next    = score_reg - (SW'(div_q) <<< 1);
                    log_y_next    = var_reg;
                    log_e_next    = 5'(MW - 1);
                    log_kind_next = 1'b1;
                    state_next    = gnb_pkg::ST_LOG_NORM;
                end
            end

            gnb_pkg::ST_CLASS_END: begin
                // first maximum wins ties
                if (!found_reg || score_reg > best_score_reg) begin
                    found_next      = 1'b1;
                    best_next       = cls_reg;
                    best_score_next = score_reg;
                end
                if (cls_last) begin
                    state_next = gnb_pkg::ST_DONE;
                end else begin
                    cls_next   = cls_reg + 1'b1;
                    state_next = gnb_pkg::ST_CLASS;
                end
            end

            gnb_pkg::ST_DONE: begin
                if (!out_valid_reg || m_tready) begin
                    out_valid_next  = 1'b1;
                    out_cls_next    = found_reg ? 2'(best_reg) : 2'd0;
                    out_status_next = !found_reg;
                    state_next      = gnb_pkg::ST_IDLE;
                end
            end

            default: begin
                state_next = gnb_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= gnb_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
            min_var_reg   <= 16'd1;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready) begin
                min_var_reg <= cfg_data;
            end
        end
        cls_reg        <= cls_next;
        feat_reg       <= feat_next;
        best_reg       <= best_next;
        found_reg      <= found_next;
        score_reg      <= score_next;
        best_score_reg <= best_score_next;
        m_reg          <= m_next;
        msq_reg        <= msq_next;
        var_reg        <= var_next;
        log_y_reg      <= log_y_next;
        log_e_reg      <= log_e_next;
        log_frac_reg   <= log_frac_next;
        log_iter_reg   <= log_iter_next;
        log_kind_reg   <= log_kind_next;
        out_cls_reg    <= out_cls_next;
        out_status_reg <= out_status_next;
        if (latch_x) begin
            x_reg[0] <= s_tdata[17:2];
            x_reg[1] <= s_tdata[33:18];
            x_reg[2] <= s_tdata[49:34];
            x_reg[3] <= s_tdata[65:50];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, out_cls_reg};
    assign m_tuser  = out_status_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    `GNB_NEVER(a_div_restart, div_start && div_busy, "divider restarted while busy")
    `GNB_ASSERT(a_no_data_class, m_tvalid && m_tuser |-> m_tdata[1:0] == 2'd0, "empty result names a class")
    `GNB_ASSERT(a_log_normalized, state_reg == gnb_pkg::ST_LOG_MUL |-> log_y_reg[MW-1], "log mantissa not normalized")
    `GNB_ASSERT(a_result_from_done, $rose(m_tvalid) |-> $past(state_reg) == gnb_pkg::ST_DONE, "result without predict")

endmodule

[hdl/gnb_mul.sv]
// shared unsigned 32x32 multiplier with registered product
// no dependencies
module gnb_mul (
    input  logic        aclk,
    input  logic [31:0] a,
    input  logic [31:0] b,
    output logic [63:0] p
);

    logic [63:0] p_reg;

    always_ff @(posedge aclk) begin
        p_reg <= 64'(a) * 64'(b);
    end

    assign p = p_reg;

endmodule

[hdl/gnb_div.sv]
// shared restoring divider, one quotient bit per cycle
// no dependencies
module gnb_div #(
    parameter int DW = 48
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic [DW-1:0] dividend,
    input  logic [DW-1:0] divisor,
    output logic          busy,
    output logic          done,
    output logic [DW-1:0] quotient,
    output logic          rem_nz
);

    localparam int CNT_W = $clog2(DW);

    logic [DW-1:0]    rem_reg, rem_next;
    logic [DW-1:0]    quo_reg, quo_next;
    logic [DW-1:0]    dvs_reg, dvs_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [DW:0]      trial;

    always_comb begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg, quo_reg[DW-1]};
        if (start) begin
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (trial >= {1'b0, dvs_reg}) begin
                rem_next = DW'(trial - {1'b0, dvs_reg});
                quo_next = {quo_reg[DW-2:0], 1'b1};
            end else begin
                rem_next = trial[DW-1:0];
                quo_next = {quo_reg[DW-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(DW - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = quo_reg;
    assign rem_nz   = (rem_reg != '0);

endmodule

[hdl/gnb_stats.sv]
// per-class training statistics: count, feature sums, sums of squares
// depends on gnb_pkg
module gnb_stats #(
    parameter int NUM_CLASSES  = 3,
    parameter int NUM_FEATURES = 4,
    parameter int COUNT_WIDTH  = 16
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  gnb_pkg::stats_cmd_t                  cmd,
    input  logic [$clog2(NUM_CLASSES)-1:0]       cls,
    input  logic [((NUM_FEATURES > 1) ? $clog2(NUM_FEATURES) : 1)-1:0] feat,
    input  logic signed [gnb_pkg::X_W-1:0]       add_x,
    input  logic [31:0]                          add_sq,
    output logic [COUNT_WIDTH-1:0]               rd_count,
    output logic signed [16+COUNT_WIDTH-1:0]     rd_sum,
    output logic [32+COUNT_WIDTH-1:0]            rd_sq
);

    localparam int SUM_W = 16 + COUNT_WIDTH;
    localparam int SQ_W  = 32 + COUNT_WIDTH;

    logic [COUNT_WIDTH-1:0]  count_reg [NUM_CLASSES];
    logic signed [SUM_W-1:0] sum_reg   [NUM_CLASSES][NUM_FEATURES];
    logic [SQ_W-1:0]         sq_reg    [NUM_CLASSES][NUM_FEATURES];

    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.clear) begin
            for (int c = 0; c < NUM_CLASSES; c++) begin
                count_reg[c] <= '0;
                for (int f = 0; f < NUM_FEATURES; f++) begin
                    sum_reg[c][f] <= '0;
                    sq_reg[c][f]  <= '0;
                end
            end
        end else begin
            if (cmd.inc) begin
                count_reg[cls] <= count_reg[cls] + 1'b1;
            end
            if (cmd.acc) begin
                sum_reg[cls][feat] <= sum_reg[cls][feat] + SUM_W'(add_x);
                sq_reg[cls][feat]  <= sq_reg[cls][feat] + SQ_W'(add_sq);
            end
        end
    end

    assign rd_count = count_reg[cls];
    assign rd_sum   = sum_reg[cls][feat];
    assign rd_sq    = sq_reg[cls][feat];

endmodule

[verif/gnb_checker.sv]
// checker for the gaussian naive bayes classifier: tracks training statistics,
// predicts each class result and compares it with the m_ channel
// depends on gnb_pkg
`timescale 1ns / 100ps

module gnb_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [71:0] s_tdata,
    input  logic [1:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [7:0]  m_tdata,
    input  logic        m_tuser,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [15:0] cfg_data,
    output int          mismatch_count,
    output int          pending,
    output int          results_seen
);

    localparam int NCLS = 3;
    localparam int NFEAT = 4;
    localparam logic [15:0] COUNT_MAX = 16'hFFFF;

    typedef struct packed {
        logic [1:0] cls;
        logic       status;
    } verdict_t;

    logic [15:0] class_cnt [NCLS];
    longint      feat_sum  [NCLS*NFEAT];
    logic [63:0] feat_sq   [NCLS*NFEAT];
    logic [15:0] var_floor;
    verdict_t    verdict_q [$];

    function automatic longint log2_q16(logic [63:0] v);
        int          e;
        logic [63:0] y;
        longint      fr;
        if (v == 0) v = 1;
        e = 63;
        fr = 0;
        while (e > 0 && !v[e]) e--;
        y = (e > 30) ? (v >> (e - 30)) : (v << (30 - e));
        repeat (gnb_pkg::LOG_ITERS) begin
            y = (y * y) >> 30;
            fr = fr << 1;
            if (y >= 64'h8000_0000) begin
                fr = fr | 1;
                y = y >> 1;
            end
        end
        return (longint'(e) << gnb_pkg::LOG_FRAC) + fr;
    endfunction

    function automatic longint floor_div(longint s, longint n);
        if (s >= 0) return s / n;
        return -((-s + n - 1) / n);
    endfunction

    // most probable class for the feature vector x
    function automatic verdict_t classify(longint x [NFEAT]);
        verdict_t    r;
        bit          found;
        longint      best, score, m, d;
        logic [63:0] n, fl, mm, msq, m2, v2, vr, dm, q;
        int          k;
        found = 0;
        best = 0;
        r = '0;
        fl = (var_floor == 0) ? 64'd1 : 64'(var_floor);
        for (int c = 0; c < NCLS; c++) begin
            n = 64'(class_cnt[c]);
            if (n == 0) continue;
            score = 2 * log2_q16(n);
            for (int f = 0; f < NFEAT; f++) begin
                k = c * NFEAT + f;
                m = floor_div(feat_sum[k], longint'(n));
                mm = (m < 0) ? 64'(-m) : 64'(m);
                msq = feat_sq[k] / n;
                m2 = mm * mm;
                v2 = (msq > m2) ? msq - m2 : 64'd0;
                vr = v2 >> 8;
                if (vr < fl) vr = fl;
                d = x[f] - m;
                dm = (d < 0) ? 64'(-d) : 64'(d);
                q = (dm * dm * 64'(gnb_pkg::INV_2LN2)) / (vr << 8);
                score = score - log2_q16(vr) - 2 * longint'(q);
            end
            if (!found || score > best) begin
                found = 1;
                best = score;
                r.cls = 2'(c);
            end
        end
        r.status = !found;
        return r;
    endfunction

    always @(posedge aclk) begin
        longint   x [NFEAT];
        logic [1:0] lbl;
        verdict_t exp_v, got;
        if (!aresetn) begin
            foreach (class_cnt[i]) class_cnt[i] = '0;
            foreach (feat_sum[i]) begin
                feat_sum[i] = 0;
                feat_sq[i] = '0;
            end
            var_floor = 16'd1;
            verdict_q.delete();
            mismatch_count = 0;
            results_seen = 0;
        end else begin
            if (cfg_valid && cfg_ready) var_floor = cfg_data;
            if (s_tvalid && s_tready) begin
                lbl = s_tdata[1:0];
                for (int f = 0; f < NFEAT; f++) x[f] = longint'($signed(s_tdata[2+16*f +: 16]));
                case (s_tuser)
                    gnb_pkg::ACT_CLEAR: begin
                        foreach (class_cnt[i]) class_cnt[i] = '0;
                        foreach (feat_sum[i]) begin
                            feat_sum[i] = 0;
                            feat_sq[i] = '0;
                        end
                    end
                    gnb_pkg::ACT_TRAIN: begin
                        if (lbl != gnb_pkg::LABEL_UNKNOWN && class_cnt[lbl] != COUNT_MAX) begin
                            class_cnt[lbl]++;
                            for (int f = 0; f < NFEAT; f++) begin
                                feat_sum[lbl*NFEAT+f] += x[f];
                                feat_sq[lbl*NFEAT+f] += 64'(x[f] * x[f]);
                            end
                        end
                    end
                    gnb_pkg::ACT_PREDICT: verdict_q.insert(verdict_q.size(), classify(x));
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                results_seen++;
                got.cls = m_tdata[1:0];
                got.status = m_tuser;
                if (verdict_q.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected result item: class %0d status %0d",
                                 got.cls, got.status);
                end else begin
                    exp_v = verdict_q.pop_front();
                    if (got != exp_v || m_tdata[7:2] != 0) begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("result mismatch: class exp %0d got %0d, status exp %0d got %0d",
                                     exp_v.cls, m_tdata, exp_v.status, got.status);
                    end
                end
            end
        end
        pending = verdict_q.size();
    end

endmodule

[verif/gaussian_naive_bayes_classifier_tb.sv]
// testbench top for the gaussian naive bayes classifier: clock, reset,
// stimulus, flow control and verdict; checking lives in gnb_checker
// depends on gnb_pkg, gnb_checker and the classifier rtl
`timescale 1ns / 100ps

module gaussian_naive_bayes_classifier_tb;

    // class labels
    localparam logic [1:0] CLS_KEEP  = 2'd0;
    localparam logic [1:0] CLS_RIGHT = 2'd1;
    localparam logic [1:0] CLS_LEFT  = 2'd2;
    localparam logic [1:0] ACT_NONE  = 2'd3;   // unused action code
    localparam int STALL_LIMIT = 60000;        // idle cycles before giving up

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [71:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [7:0]  m_tdata;
    logic        m_tuser;
    logic        cfg_valid = 0;
    logic        cfg_ready;
    logic [15:0] cfg_data = '0;

    int mismatch_count, pending, results_seen;
    int items_sent = 0;
    int trains_sent = 0;
    bit no_gaps = 0;        // stretch with neither side idling
    bit hold_req = 0;       // ask the receiver for a long hold-off
    int hold_left = 0;
    int stall_cycles = 0;
    logic signed [15:0] center [3][4];

    always #10 aclk = ~aclk;

    gaussian_naive_bayes_classifier u_top (.*);

    gnb_checker u_checker (.*);

    // receiver: random back-pressure, plus an occasional long hold-off
    // long enough for two predicts to finish behind it
    always @(posedge aclk) begin
        if (hold_req && hold_left == 0) hold_left <= 8000;
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready <= 0;
            if (hold_left == 1) hold_req <= 0;
        end else begin
            m_tready <= no_gaps || ($urandom_range(99) >= 26);
        end
    end

    // watchdog: cycles with no item moving on any channel
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)
            || !aresetn)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("watchdog expired with %0d results outstanding", pending);
            $display("Regression FAIL");
            $finish;
        end
    end

    // offer one item and wait until it is taken, then maybe idle
    task automatic send(logic [1:0] act, logic [1:0] lbl, logic [15:0] f0, logic [15:0] f1,
                        logic [15:0] f2, logic [15:0] f3);
        s_tvalid <= 1;
        s_tuser  <= act;
        s_tdata  <= {6'd0, f3, f2, f1, f0, lbl};
        do @(posedge aclk); while (!s_tready);
        items_sent++;
        if (act == gnb_pkg::ACT_TRAIN) trains_sent++;
        if (!no_gaps && $urandom_range(99) < 26) begin
            s_tvalid <= 0;
            repeat ($urandom_range(6, 1)) @(posedge aclk);
        end
    endtask

    task automatic drain();
        s_tvalid <= 0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        // a trailing train or clear may still be in flight
        repeat (30) @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // min_variance write, only with the block idle
    task automatic set_floor(logic [15:0] v);
        drain();
        cfg_valid <= 1;
        cfg_data  <= v;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 0;
    endtask

    // sample near a class center, sometimes anywhere in range
    task automatic train_near(logic [1:0] c, int spread);
        logic [15:0] f [4];
        for (int i = 0; i < 4; i++)
            f[i] = ($urandom_range(9) == 0) ? 16'($urandom)
                 : 16'(center[c][i] + $signed($urandom_range(2*spread)) - spread);
        send(gnb_pkg::ACT_TRAIN, c, f[0], f[1], f[2], f[3]);
    endtask

    task automatic random_item();
        int          r;
        logic [1:0]  c;
        logic [15:0] f [4];
        r = $urandom_range(99);
        c = 2'($urandom_range(2));
        for (int i = 0; i < 4; i++)
            f[i] = ($urandom_range(3) == 0) ? 16'($urandom)
                 : 16'(center[c][i] + $signed($urandom_range(2048)) - 1024);
        if (r < 55)      send(gnb_pkg::ACT_TRAIN, c, f[0], f[1], f[2], f[3]);
        else if (r < 92) send(gnb_pkg::ACT_PREDICT, 2'($urandom), f[0], f[1], f[2], f[3]);
        else if (r < 95) send(gnb_pkg::ACT_TRAIN, gnb_pkg::LABEL_UNKNOWN,
                              f[0], f[1], f[2], f[3]);
        else if (r < 97) send(ACT_NONE, 2'($urandom), f[0], f[1], f[2], f[3]);
        else             send(gnb_pkg::ACT_CLEAR, 2'($urandom), f[0], f[1], f[2], f[3]);
    endtask

    initial begin
        logic [15:0] floors [6];
        floors = '{16'd1, 16'd65535, 16'd0, 16'd16, 16'd256, 16'd4};
        foreach (center[c, i]) center[c][i] = 16'($signed($urandom_range(20000)) - 10000);

        repeat (9) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // directed: empty model, extremes, unknown label, unused action, ties
        send(gnb_pkg::ACT_PREDICT, CLS_KEEP, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        send(gnb_pkg::ACT_TRAIN, gnb_pkg::LABEL_UNKNOWN, 16'h7fff, 16'h8000, 16'h7fff,
             16'h8000);
        send(ACT_NONE, CLS_KEEP, 16'h1234, 16'h0000, 16'h0000, 16'h0000);
        send(gnb_pkg::ACT_PREDICT, CLS_LEFT, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
        // left only: the last class wins when alone
        send(gnb_pkg::ACT_TRAIN, CLS_LEFT, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
        send(gnb_pkg::ACT_TRAIN, CLS_LEFT, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
        send(gnb_pkg::ACT_PREDICT, CLS_KEEP, 16'h8000, 16'h7fff, 16'h0000, 16'hffff);
        // identical keep and right statistics tie, lower class wins
        send(gnb_pkg::ACT_CLEAR, CLS_KEEP, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
        send(gnb_pkg::ACT_TRAIN, CLS_KEEP, 16'h0100, 16'hff00, 16'h0200, 16'h0000);
        send(gnb_pkg::ACT_TRAIN, CLS_RIGHT, 16'h0100, 16'hff00, 16'h0200, 16'h0000);
        send(gnb_pkg::ACT_PREDICT, CLS_KEEP, 16'h0100, 16'hff00, 16'h0200, 16'h0000);
        send(gnb_pkg::ACT_TRAIN, CLS_KEEP, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff);
        send(gnb_pkg::ACT_TRAIN, CLS_RIGHT, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000);
        send(gnb_pkg::ACT_TRAIN, CLS_LEFT, 16'h0001, 16'hfffe, 16'h5555, 16'haaaa);
        send(gnb_pkg::ACT_PREDICT, CLS_KEEP, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff);
        send(gnb_pkg::ACT_PREDICT, CLS_KEEP, 16'haaaa, 16'h5555, 16'h0000, 16'h0001);
        send(gnb_pkg::ACT_CLEAR, CLS_KEEP, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        send(gnb_pkg::ACT_PREDICT, CLS_KEEP, 16'h0000, 16'h0000, 16'h0000, 16'h0000);

        // random phases, one per variance floor
        foreach (floors[p]) begin
            set_floor(floors[p]);
            no_gaps = (p == 1);
            for (int i = 0; i < 12; i++) train_near(2'($urandom_range(2)), 512);
            for (int i = 0; i < 210; i++) begin
                random_item();
                if (i == 60) hold_req = 1;        // receiver stalls, input backs up
                if (i == 120) drain();            // sender waits for every result
            end
        end
        no_gaps = 0;

        // short run at the default floor with only the right class trained
        set_floor(16'd1);
        send(gnb_pkg::ACT_CLEAR, CLS_KEEP, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        send(gnb_pkg::ACT_TRAIN, CLS_RIGHT, 16'h0080, 16'h0010, 16'hff00, 16'h0040);
        send(gnb_pkg::ACT_TRAIN, CLS_RIGHT, 16'h0090, 16'h0000, 16'hff10, 16'h0040);
        for (int i = 0; i < 6; i++)
            send(gnb_pkg::ACT_PREDICT, CLS_KEEP, 16'($urandom_range(255)), 16'($urandom),
                 16'hff00, 16'h0040);

        drain();
        repeat (100) @(posedge aclk);
        $display("sent %0d input items (%0d train) across 6 floor settings, %0d results checked",
                 items_sent, trains_sent, results_seen);
        if (mismatch_count == 0 && pending == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

[files.f]
+incdir+hdl
hdl/gnb_pkg.sv
hdl/gnb_mul.sv
hdl/gnb_div.sv
hdl/gnb_stats.sv
hdl/gaussian_naive_bayes_classifier.sv
verif/gnb_checker.sv
verif/gaussian_naive_bayes_classifier_tb.sv
